### design/fdd_pkg.sv
package fdd_pkg;

    // Field widths of the request and result payloads.
    localparam int SAMPLE_BITS = 16;
    localparam int VAL_W       = 24;
    localparam int ORD_W       = 2;
    localparam int POS_W       = 8;

    // Configuration port.
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_LAST   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_SPAN      = 2'd3;

    localparam logic [6:0]       RST_FEATURE_COUNT = 7'd13;
    localparam logic [ORD_W-1:0] RST_ORDER_COUNT   = 2'd2;

    // Request operations.
    localparam logic OP_ELEMENT = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    // Default sizes for the top level parameters.
    localparam int DEF_MAX_FEATURES = 64;
    localparam int DEF_MAX_ORDERS   = 3;

    typedef struct packed {
        logic                          op;
        logic signed [SAMPLE_BITS-1:0] sample;
    } in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [ORD_W-1:0]        order;
        logic [POS_W-1:0]        position;
        logic                    last;
    } out_t;

    // Token that walks along the cell chain, one cell per step.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [ORD_W-1:0]        order;
        logic [ORD_W-1:0]        kmax;
        logic [POS_W-1:0]        position;
        logic [POS_W-1:0]        step;
        logic                    prime;
        logic                    span;
    } tok_t;

    // History store control broadcast from the head to every cell.
    typedef struct packed {
        logic rd_en;
        logic clr;
    } hist_ctl_t;

    // Address width for a store of the given depth, at least one bit.
    function automatic int idx_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

### design/feature_delta_differencer.sv
// Channel   Handshake              Payload    Moves
// config    cfg_we                 cfg_index  one register write
//                                  cfg_data
// input     in_valid / in_stall    in_data    one request: element or clear
// output    out_valid / out_stall  out_data   one result: value of one order
//
// An element request gives order_count + 1 results (order_count clamped to
// MAX_ORDERS), one per cycle unless out_stall holds a waiting result; they
// come from the token walking the cell chain, one cell per cycle under the
// same condition, into the single output register. The next request is taken
// at the edge that hands over the last result. Reset and clear zero the history
// through per-entry valid flags, with no clearing pass. out_stall freezes the chain.
module feature_delta_differencer #(
    parameter int MAX_FEATURES = fdd_pkg::DEF_MAX_FEATURES,
    parameter int MAX_ORDERS   = fdd_pkg::DEF_MAX_ORDERS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fdd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fdd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  fdd_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output fdd_pkg::out_t                 out_data
);
    import fdd_pkg::*;

    localparam int IDX_W = idx_bits(MAX_FEATURES);

    logic [MAX_ORDERS:0] stage_vld;
    tok_t                stage_tok [MAX_ORDERS+1];
    hist_ctl_t           ctl;
    logic [IDX_W-1:0]    rd_addr, wr_addr;

    logic                adv;
    logic                accept;
    logic                busy;
    logic                finish;
    tok_t                sel_tok;

    logic                out_vld_reg, out_vld_next;
    out_t                out_data_reg, out_data_next;

    // The chain moves whenever the output register is free or being taken.
    assign adv      = !out_vld_reg || !out_stall;
    assign busy     = |stage_vld;
    assign finish   = adv && busy && (sel_tok.order == sel_tok.kmax);
    assign in_stall = busy && !finish;
    assign accept   = in_valid && !in_stall;

    fdd_head #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_ORDERS   (MAX_ORDERS)
    ) u_head (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .req       (in_data),
        .adv       (adv),
        .tok_vld   (stage_vld[0]),
        .tok       (stage_tok[0]),
        .ctl       (ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr)
    );

    // One cell per difference order.
    for (genvar g = 1; g <= MAX_ORDERS; g++)
    begin : g_cell
        fdd_cell #(
            .MAX_FEATURES (MAX_FEATURES),
            .ORDER        (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .rd_addr  (rd_addr),
            .wr_addr  (wr_addr),
            .adv      (adv),
            .prev_vld (stage_vld[g-1]),
            .prev_tok (stage_tok[g-1]),
            .tok_vld  (stage_vld[g]),
            .tok      (stage_tok[g])
        );
    end

    // At most one stage holds the token; pick it for the output register.
    always_comb
    begin
        sel_tok = '0;
        for (int s = 0; s <= MAX_ORDERS; s++)
        begin
            if (stage_vld[s])
            begin
                sel_tok = stage_tok[s];
            end
        end
    end

    // Output register.
    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        if (adv)
        begin
            out_vld_next           = busy;
            out_data_next.value    = sel_tok.value;
            out_data_next.order    = sel_tok.order;
            out_data_next.position = sel_tok.position;
            out_data_next.last     = (sel_tok.order == sel_tok.kmax);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    // Only one item is ever in the chain.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(stage_vld))
        else $error("more than one token in the cell chain");

    // An accepted element request enters the head stage.
    a_head_load: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.op == OP_ELEMENT)) |=> stage_vld[0])
        else $error("accepted element did not enter the head stage");

    // A taken result that is not the last is followed at once by the next order.
    a_order_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !out_data.last) |=>
        (out_valid && (out_data.order == ORD_W'($past(out_data.order) + 1'b1))))
        else $error("results of one request out of order");

endmodule

### design/fdd_head.sv
module fdd_head #(
    parameter int MAX_FEATURES = fdd_pkg::DEF_MAX_FEATURES,
    parameter int MAX_ORDERS   = fdd_pkg::DEF_MAX_ORDERS
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [fdd_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  logic [fdd_pkg::CFG_W-1:0]                   cfg_data,
    input  logic                                        accept,
    input  fdd_pkg::in_t                                req,
    input  logic                                        adv,
    output logic                                        tok_vld,
    output fdd_pkg::tok_t                               tok,
    output fdd_pkg::hist_ctl_t                          ctl,
    output logic [fdd_pkg::idx_bits(MAX_FEATURES)-1:0]  rd_addr,
    output logic [fdd_pkg::idx_bits(MAX_FEATURES)-1:0]  wr_addr
);
    import fdd_pkg::*;

    localparam int IDX_W = idx_bits(MAX_FEATURES);
    localparam int FW    = $clog2(MAX_FEATURES + 1);
    localparam int CW    = (FW > 7) ? FW : 7;

    logic [6:0]       feature_count_reg;
    logic [ORD_W-1:0] order_count_reg;
    logic             energy_last_reg;
    logic             two_span_reg;

    logic [IDX_W-1:0] counter_reg, counter_next;
    logic             primed_reg, primed_next;
    logic [IDX_W-1:0] e_reg, e_next;
    logic             tok_vld_reg, tok_vld_next;
    tok_t             tok_reg, tok_next;

    logic [CW-1:0]    f_wide;
    logic [FW-1:0]    f_eff;
    logic [FW-1:0]    f_m1;
    logic             frame_end;
    logic [ORD_W-1:0] kmax;
    logic [POS_W-1:0] f_pos;
    logic [POS_W-1:0] fm1_pos;
    logic [POS_W-1:0] tail_base;
    logic             is_element;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_count_reg <= RST_FEATURE_COUNT;
            order_count_reg   <= RST_ORDER_COUNT;
            energy_last_reg   <= 1'b0;
            two_span_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FEATURE_COUNT: feature_count_reg <= cfg_data;
                REG_ORDER_COUNT:   order_count_reg   <= cfg_data[ORD_W-1:0];
                REG_ENERGY_LAST:   energy_last_reg   <= cfg_data[0];
                REG_TWO_SPAN:      two_span_reg      <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Effective frame length and order count, clamped to the built sizes; a frame length of zero counts as one.
    always_comb
    begin
        f_wide = CW'(feature_count_reg);
        if (f_wide == '0)
        begin
            f_wide = CW'(1);
        end
        else if (f_wide > CW'(MAX_FEATURES))
        begin
            f_wide = CW'(MAX_FEATURES);
        end
        f_eff = FW'(f_wide);
        f_m1  = f_eff - FW'(1);

        if (int'(order_count_reg) > MAX_ORDERS)
        begin
            kmax = ORD_W'(MAX_ORDERS);
        end
        else
        begin
            kmax = order_count_reg;
        end
    end

    // Element index within the frame and the start of its position walk.
    always_comb
    begin
        frame_end = (FW'(counter_reg) >= f_m1);
        e_next    = frame_end ? IDX_W'(f_m1) : counter_reg;
        f_pos     = POS_W'(f_eff);
        fm1_pos   = POS_W'(f_m1);
        tail_base = POS_W'({1'b0, kmax} + 3'd1) * fm1_pos;
    end

    // Next state of the counter, the priming flag and the head token.
    always_comb
    begin
        is_element   = accept && (req.op == OP_ELEMENT);
        counter_next = counter_reg;
        primed_next  = primed_reg;
        tok_vld_next = tok_vld_reg;
        tok_next     = tok_reg;

        if (accept && (req.op == OP_CLEAR))
        begin
            counter_next = '0;
        end
        else if (is_element)
        begin
            counter_next = frame_end ? '0 : counter_reg + IDX_W'(1);
            if (frame_end && (kmax != '0))
            begin
                primed_next = 1'b1;
            end
        end

        if (is_element)
        begin
            tok_vld_next   = 1'b1;
            tok_next.value = VAL_W'($signed(req.sample));
            tok_next.order = '0;
            tok_next.kmax  = kmax;
            tok_next.prime = !primed_reg;
            tok_next.span  = two_span_reg;
            if (energy_last_reg && frame_end)
            begin
                // The frame's last feature goes after every other order.
                tok_next.position = tail_base;
                tok_next.step     = POS_W'(1);
            end
            else if (energy_last_reg)
            begin
                tok_next.position = POS_W'(e_next);
                tok_next.step     = fm1_pos;
            end
            else
            begin
                tok_next.position = POS_W'(e_next);
                tok_next.step     = f_pos;
            end
        end
        else if (adv)
        begin
            tok_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            primed_reg  <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            counter_reg <= counter_next;
            primed_reg  <= primed_next;
            tok_vld_reg <= tok_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (is_element)
        begin
            e_reg <= e_next;
        end
    end

    assign tok_vld   = tok_vld_reg;
    assign tok       = tok_reg;
    assign ctl.rd_en = is_element;
    assign ctl.clr   = accept && (req.op == OP_CLEAR);
    assign rd_addr   = e_next;
    assign wr_addr   = e_reg;

endmodule

### design/fdd_cell.sv
module fdd_cell #(
    parameter int MAX_FEATURES = fdd_pkg::DEF_MAX_FEATURES,
    parameter int ORDER        = 1
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  fdd_pkg::hist_ctl_t                          ctl,
    input  logic [fdd_pkg::idx_bits(MAX_FEATURES)-1:0]  rd_addr,
    input  logic [fdd_pkg::idx_bits(MAX_FEATURES)-1:0]  wr_addr,
    input  logic                                        adv,
    input  logic                                        prev_vld,
    input  fdd_pkg::tok_t                               prev_tok,
    output logic                                        tok_vld,
    output fdd_pkg::tok_t                               tok
);
    import fdd_pkg::*;

    localparam int IDX_W = idx_bits(MAX_FEATURES);
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // Stored values of the previous order, one and two frames back.
    logic signed [VAL_W-1:0] recent_mem [MAX_FEATURES];
    logic signed [VAL_W-1:0] older_mem  [MAX_FEATURES];

    logic [MAX_FEATURES-1:0] vld_reg, vld_next;
    logic signed [VAL_W-1:0] rd_recent_reg, rd_older_reg;
    logic                    rd_vld_reg;
    logic                    tok_vld_reg, tok_vld_next;
    tok_t                    tok_reg, tok_next;

    logic                    take;
    logic                    priming;
    logic signed [VAL_W-1:0] recent_ref, older_ref, sub, older_wr;
    logic signed [VAL_W:0]   diff;
    logic signed [VAL_W-1:0] diff_sat;

    // Difference against the stored value, with priming and saturation.
    always_comb
    begin
        take       = adv && prev_vld && (prev_tok.order != prev_tok.kmax);
        priming    = (ORDER == 1) && prev_tok.prime;
        recent_ref = rd_vld_reg ? rd_recent_reg : '0;
        older_ref  = rd_vld_reg ? rd_older_reg : '0;

        if (priming)
        begin
            sub      = prev_tok.value;
            older_wr = prev_tok.value;
        end
        else
        begin
            sub      = prev_tok.span ? older_ref : recent_ref;
            older_wr = recent_ref;
        end

        diff = {prev_tok.value[VAL_W-1], prev_tok.value} - {sub[VAL_W-1], sub};
        if (diff[VAL_W] != diff[VAL_W-1])
        begin
            diff_sat = diff[VAL_W] ? VAL_MIN : VAL_MAX;
        end
        else
        begin
            diff_sat = diff[VAL_W-1:0];
        end
    end

    // Token hand-over and entry valid flags.
    always_comb
    begin
        tok_next     = tok_reg;
        tok_vld_next = tok_vld_reg;
        if (take)
        begin
            tok_next          = prev_tok;
            tok_next.value    = diff_sat;
            tok_next.order    = prev_tok.order + ORD_W'(1);
            tok_next.position = prev_tok.position + prev_tok.step;
            tok_vld_next      = 1'b1;
        end
        else if (adv)
        begin
            tok_vld_next = 1'b0;
        end

        vld_next = ctl.clr ? '0 : vld_reg;
        if (take)
        begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= vld_next;
            tok_vld_reg <= tok_vld_next;
        end
    end

    // Store ports: read when the request is accepted, write on hand-over.
    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (take)
        begin
            recent_mem[wr_addr] <= prev_tok.value;
            older_mem[wr_addr]  <= older_wr;
        end
        if (ctl.rd_en)
        begin
            rd_recent_reg <= recent_mem[rd_addr];
            rd_older_reg  <= older_mem[rd_addr];
            rd_vld_reg    <= vld_reg[rd_addr];
        end
    end

    assign tok_vld = tok_vld_reg;
    assign tok     = tok_reg;

endmodule

### sim/fdd_checker.sv
module fdd_checker #(
    parameter int MAX_FEATURES = fdd_pkg::DEF_MAX_FEATURES,
    parameter int MAX_ORDERS   = fdd_pkg::DEF_MAX_ORDERS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fdd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fdd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  fdd_pkg::in_t                  in_data,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  fdd_pkg::out_t                 out_data,
    output int                            mismatches,
    output int                            results_due
);

    timeunit 1ns;
    timeprecision 1ps;

    import fdd_pkg::*;

    localparam int SAT_HI = (1 << (VAL_W - 1)) - 1;
    localparam int SAT_LO = -(1 << (VAL_W - 1));

    // Own copy of the history, the frame position and the registers.
    logic signed [VAL_W-1:0] hist_recent [MAX_ORDERS*MAX_FEATURES];
    logic signed [VAL_W-1:0] hist_older  [MAX_ORDERS*MAX_FEATURES];
    int                      elem_pos;
    bit                      primed;
    logic [6:0]              cfg_features;
    logic [ORD_W-1:0]        cfg_orders;
    bit                      cfg_moved;
    bit                      cfg_span;

    // Results still owed by the block, oldest first.
    out_t due_deltas [$];

    initial mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic clear_history();
        for (int i = 0; i < MAX_ORDERS * MAX_FEATURES; i++)
        begin
            hist_recent[i] = '0;
            hist_older[i]  = '0;
        end
        elem_pos = 0;
    endtask

    // Works out the value of every order for one feature element and
    // refreshes the history with this frame's values.
    task automatic predict_deltas(input logic signed [SAMPLE_BITS-1:0] smp);
        int                      f;
        int                      kmax;
        int                      e;
        int                      idx;
        int                      pos;
        int                      d;
        bit                      frame_end;
        logic signed [VAL_W-1:0] y [MAX_ORDERS+1];
        logic signed [VAL_W-1:0] held;
        out_t                    res;

        f = (cfg_features == 0) ? 1 : int'(cfg_features);
        if (f > MAX_FEATURES)
            f = MAX_FEATURES;
        kmax = (int'(cfg_orders) > MAX_ORDERS) ? MAX_ORDERS : int'(cfg_orders);

        // A counter past the end of the frame is folded onto the last feature.
        e = elem_pos;
        frame_end = (e >= f - 1);
        if (e > f - 1)
            e = f - 1;
        elem_pos = frame_end ? 0 : elem_pos + 1;

        y[0] = {{(VAL_W - SAMPLE_BITS){smp[SAMPLE_BITS-1]}}, smp};

        if (kmax > 0)
        begin
            // Until the first full frame, the raw value stands in as its own history.
            if (!primed)
            begin
                hist_recent[e] = y[0];
                hist_older[e]  = y[0];
            end
            for (int k = 1; k <= kmax; k++)
            begin
                idx  = (k - 1) * MAX_FEATURES + e;
                held = cfg_span ? hist_older[idx] : hist_recent[idx];
                d    = int'(y[k-1]) - int'(held);
                if (d > SAT_HI)
                    d = SAT_HI;
                else if (d < SAT_LO)
                    d = SAT_LO;
                y[k] = d[VAL_W-1:0];
                hist_older[idx]  = hist_recent[idx];
                hist_recent[idx] = y[k-1];
            end
            if (frame_end)
                primed = 1'b1;
        end

        for (int k = 0; k <= kmax; k++)
        begin
            if (!cfg_moved)
                pos = k * f + e;
            else if (e < f - 1)
                pos = k * (f - 1) + e;
            else
                pos = (kmax + 1) * (f - 1) + k;
            res.value    = y[k];
            res.order    = k[ORD_W-1:0];
            res.position = pos[POS_W-1:0];
            res.last     = (k == kmax);
            due_deltas.push_back(res);
        end
    endtask

    task automatic check_result(input out_t got);
        out_t want;

        if (due_deltas.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing owed: value %0d order %0d position %0d",
                                      got.value, got.order, got.position));
            return;
        end
        want = due_deltas.pop_front();
        if (got.value !== want.value)
            report_mismatch($sformatf("value: expected %0d, got %0d (order %0d, position %0d)",
                                      want.value, got.value, want.order, want.position));
        if (got.order !== want.order)
            report_mismatch($sformatf("order: expected %0d, got %0d", want.order, got.order));
        if (got.position !== want.position)
            report_mismatch($sformatf("position: expected %0d, got %0d (order %0d)",
                                      want.position, got.position, want.order));
        if (got.last !== want.last)
            report_mismatch($sformatf("last: expected %0b, got %0b (order %0d)",
                                      want.last, got.last, want.order));
    endtask

    // Follow register writes, requests and results edge by edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_history();
            primed       = 1'b0;
            cfg_features = RST_FEATURE_COUNT;
            cfg_orders   = RST_ORDER_COUNT;
            cfg_moved    = 1'b0;
            cfg_span     = 1'b0;
            due_deltas.delete();
            results_due <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FEATURE_COUNT: cfg_features = cfg_data[6:0];
                    REG_ORDER_COUNT:   cfg_orders   = cfg_data[ORD_W-1:0];
                    REG_ENERGY_LAST:   cfg_moved    = cfg_data[0];
                    REG_TWO_SPAN:      cfg_span     = cfg_data[0];
                    default:           ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (in_data.op == OP_CLEAR)
                    clear_history();
                else
                    predict_deltas(in_data.sample);
            end
            if (out_valid && !out_stall)
                check_result(out_data);
            results_due <= due_deltas.size();
        end
    end

endmodule

### sim/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fdd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 80;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_t                  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_t                 out_data;

    int mismatches;
    int results_due;
    int cycle_count = 0;
    bit quiet_run   = 1'b0;

    feature_delta_differencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    fdd_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Give up if the run hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // The result side stalls now and then, except during the quiet stretch.
    always @(posedge clk)
        out_stall <= !quiet_run && ($urandom_range(0, 99) < 10);

    // Offer one request, with an occasional gap first, and hold it until taken.
    task automatic send_request(input in_t req);
        while (!quiet_run && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_element(input logic signed [SAMPLE_BITS-1:0] smp);
        in_t req;

        req.op     = OP_ELEMENT;
        req.sample = smp;
        send_request(req);
    endtask

    // The sample bits of a clear carry noise; the block must ignore them.
    task automatic send_clear();
        in_t req;

        req.op     = OP_CLEAR;
        req.sample = SAMPLE_BITS'($urandom);
        send_request(req);
    endtask

    // Stop sending and wait until every owed result has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_due != 0);
        repeat (8) @(posedge clk);
    endtask

    // Write all four registers on consecutive edges; only called while idle.
    task automatic set_config(input logic [6:0] feats, input logic [ORD_W-1:0] orders,
                              input bit moved, input bit span);
        logic [CFG_IDX_W-1:0] regs [4];
        logic [CFG_W-1:0]     vals [4];

        regs = '{REG_FEATURE_COUNT, REG_ORDER_COUNT, REG_ENERGY_LAST, REG_TWO_SPAN};
        vals = '{feats, CFG_W'(orders), CFG_W'(moved), CFG_W'(span)};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly arbitrary samples, with the range limits mixed in.
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        logic signed [SAMPLE_BITS-1:0] s;

        s = SAMPLE_BITS'($urandom);
        if ($urandom_range(0, 99) < 10)
        begin
            case ($urandom_range(0, 3))
                0: s = 16'sh7fff;
                1: s = 16'sh8000;
                2: s = 16'sh0000;
                default: s = 16'shffff;
            endcase
        end
        return s;
    endfunction

    initial
    begin
        int         sent;
        int         phase;
        int         roll;
        int         eff;
        int         n_items;
        logic [6:0] feats;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Three frames of two features at the top order: priming, then real history.
        set_config(7'd2, 2'd3, 1'b0, 1'b0);
        send_element(16'sh7fff);
        send_element(16'sh8000);
        send_element(16'sh0000);
        send_element(16'shffff);
        send_element(16'sh8000);
        send_element(16'sh7fff);

        // A clear empties the history but the block stays primed.
        send_clear();
        send_element(16'sh0001);
        send_element(16'sh0002);
        drain_results();

        // Moved layout and the two-frame span.
        set_config(7'd3, 2'd2, 1'b1, 1'b1);
        repeat (6) send_element(pick_sample());
        drain_results();

        // No difference orders: plain pass-through with a single feature.
        set_config(7'd1, 2'd0, 1'b0, 1'b0);
        send_element(16'sh7fff);
        send_element(16'sh8000);
        drain_results();

        // A feature count of zero behaves as one.
        set_config(7'd0, 2'd1, 1'b1, 1'b0);
        send_element(16'sh1234);
        send_element(16'shedcb);
        drain_results();

        // An oversized feature count is held to the store size.
        set_config(7'd127, 2'd3, 1'b0, 1'b1);
        send_element(pick_sample());
        send_element(pick_sample());
        drain_results();

        // Shrink the frame under a counter that is already past its end.
        set_config(7'd2, 2'd3, 1'b1, 1'b0);
        send_element(pick_sample());
        send_element(pick_sample());
        drain_results();

        // Random phases: mostly whole frames of small size, some clears and stubs.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            quiet_run <= (phase >= 1 && phase <= 3);
            roll = $urandom_range(0, 99);
            if (roll < 70)
                feats = 7'($urandom_range(1, 6));
            else if (roll < 80)
                feats = 7'($urandom_range(7, 16));
            else if (roll < 88)
                feats = 7'd0;
            else
                feats = 7'($urandom_range(64, 127));
            set_config(feats, ORD_W'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

            eff = (feats == 0) ? 1 : ((feats > 64) ? 64 : int'(feats));
            if (eff > 16)
                n_items = $urandom_range(3, 12);
            else
            begin
                n_items = eff * $urandom_range(2, 5);
                if ($urandom_range(0, 3) == 0)
                    n_items += $urandom_range(0, eff - 1);
            end

            for (int i = 0; i < n_items && sent < RANDOM_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) < 3)
                    drain_results();
                if ($urandom_range(0, 99) < 4)
                    send_clear();
                else
                    send_element(pick_sample());
                sent++;
            end
            drain_results();
            phase++;
        end

        drain_results();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
